// File: hdl/json_subset_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// json_subset_tokenizer_assert
// Assertion macros used by the checker file of the tokenizer.
// ----------------------------------------------------------------------------
// Both macros expect signals named clk and rst_n in the enclosing scope.
`ifndef JSON_SUBSET_TOKENIZER_ASSERT_SVH
`define JSON_SUBSET_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define JST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define JST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/jst_pkg.sv
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and codes of the JSON subset tokenizer: token kinds, error
// codes, the result item and the queue record that carries one or two results.
// ----------------------------------------------------------------------------
package jst_pkg;

  localparam int TEXT_MAX_DEF    = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int KIND_W = 4;
  localparam int LEN_W  = 5;
  localparam int ERR_W  = 4;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_LBRACE   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RBRACE   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LBRACKET = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RBRACKET = 4'd3;
  localparam logic [KIND_W-1:0] KIND_COLON    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_STRING   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_NUMBER   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_TRUE     = 4'd8;
  localparam logic [KIND_W-1:0] KIND_FALSE    = 4'd9;
  localparam logic [KIND_W-1:0] KIND_EOF      = 4'd10;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 4'd11;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE         = 4'd0;
  localparam logic [ERR_W-1:0] ERR_READ         = 4'd1;
  localparam logic [ERR_W-1:0] ERR_UNTERMINATED = 4'd2;
  localparam logic [ERR_W-1:0] ERR_ESCAPE       = 4'd3;
  localparam logic [ERR_W-1:0] ERR_STRING_LONG  = 4'd4;
  localparam logic [ERR_W-1:0] ERR_NUMBER_LONG  = 4'd5;
  localparam logic [ERR_W-1:0] ERR_EXPONENT     = 4'd6;
  localparam logic [ERR_W-1:0] ERR_LITERAL      = 4'd7;
  localparam logic [ERR_W-1:0] ERR_UNEXPECTED   = 4'd8;

  // One result item, without the last mark, which the back end adds.
  typedef struct packed {
    logic              is_token;
    logic [KIND_W-1:0] token_kind;
    logic [7:0]        text_byte;
    logic [LEN_W-1:0]  text_length;
    logic [ERR_W-1:0]  error_code;
  } res_t;

  // Everything one input byte produces: one result, or two when a number
  // ends on a byte that itself yields a result.
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } rec_t;

endpackage

// File: hdl/jst_front.sv
// ----------------------------------------------------------------------------
// jst_front
// Lexer front end: classifies each source byte, advances the lexer state and
// builds the record of results that the byte causes.
// ----------------------------------------------------------------------------
module jst_front #(
  parameter int TEXT_MAX = jst_pkg::TEXT_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_input,
  input  logic              read_error,
  output logic              push,
  output jst_pkg::rec_t     rec
);

  localparam int CW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STRING  = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_LITERAL = 3'd3,
    MODE_ERROR   = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    CLS_WS, CLS_LBRACE, CLS_RBRACE, CLS_LBRACKET, CLS_RBRACKET, CLS_COLON,
    CLS_COMMA, CLS_QUOTE, CLS_BSLASH, CLS_T, CLS_F, CLS_MINUS, CLS_DIGIT,
    CLS_DOT, CLS_EXP, CLS_OTHER
  } cls_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = CLS_OTHER;
    if (c >= "0" && c <= "9") r = CLS_DIGIT;
    else if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) r = CLS_WS;
    else if (c == "{") r = CLS_LBRACE;
    else if (c == "}") r = CLS_RBRACE;
    else if (c == "[") r = CLS_LBRACKET;
    else if (c == "]") r = CLS_RBRACKET;
    else if (c == ":") r = CLS_COLON;
    else if (c == ",") r = CLS_COMMA;
    else if (c == 8'h22) r = CLS_QUOTE;
    else if (c == 8'h5C) r = CLS_BSLASH;
    else if (c == "t") r = CLS_T;
    else if (c == "f") r = CLS_F;
    else if (c == "-") r = CLS_MINUS;
    else if (c == ".") r = CLS_DOT;
    else if (c == "e" || c == "E") r = CLS_EXP;
    return r;
  endfunction

  // Expected character of a literal's tail: {in range, final, character}.
  function automatic logic [9:0] lit_expect(input logic is_true, input logic [2:0] pos);
    logic [9:0] r;
    r = '0;
    if (is_true) begin
      case (pos)
        3'd0:    r = {2'b10, 8'("r")};
        3'd1:    r = {2'b10, 8'("u")};
        3'd2:    r = {2'b11, 8'("e")};
        default: r = '0;
      endcase
    end else begin
      case (pos)
        3'd0:    r = {2'b10, 8'("a")};
        3'd1:    r = {2'b10, 8'("l")};
        3'd2:    r = {2'b10, 8'("s")};
        3'd3:    r = {2'b11, 8'("e")};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic jst_pkg::res_t mk_tok(input logic [jst_pkg::KIND_W-1:0] kind);
    jst_pkg::res_t r;
    r = '0;
    r.is_token   = 1'b1;
    r.token_kind = kind;
    return r;
  endfunction

  function automatic jst_pkg::res_t mk_err(input logic [jst_pkg::ERR_W-1:0] code);
    jst_pkg::res_t r;
    r = mk_tok(jst_pkg::KIND_ERROR);
    r.error_code = code;
    return r;
  endfunction

  function automatic jst_pkg::res_t mk_text(input logic [jst_pkg::KIND_W-1:0] kind,
                                            input logic [7:0] c);
    jst_pkg::res_t r;
    r = '0;
    r.token_kind = kind;
    r.text_byte  = c;
    return r;
  endfunction

  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          lit_true_r, lit_true_nxt;
  logic [2:0]    lit_pos_r, lit_pos_nxt;

  cls_t          cls;
  logic          full;
  logic [9:0]    lit;

  // Outcome of the byte taken as the start of a token.
  logic          ie_emit;
  jst_pkg::res_t ie_res;
  mode_t         ie_mode;
  logic          ie_cnt_ld;
  logic [CW-1:0] ie_cnt;
  logic          ie_lit_ld;

  logic          emit;

  assign cls  = classify(data_byte);
  assign full = (count_r == CW'(TEXT_MAX - 1));
  assign lit  = lit_expect(lit_true_r, lit_pos_r);

  always_comb begin
    ie_emit   = 1'b0;
    ie_res    = '0;
    ie_mode   = MODE_IDLE;
    ie_cnt_ld = 1'b0;
    ie_cnt    = '0;
    ie_lit_ld = 1'b0;
    if (read_error) begin
      ie_emit = 1'b1;
      ie_res  = mk_err(jst_pkg::ERR_READ);
      ie_mode = MODE_ERROR;
    end else if (end_of_input) begin
      ie_emit = 1'b1;
      ie_res  = mk_tok(jst_pkg::KIND_EOF);
    end else begin
      unique case (cls)
        CLS_WS: ;
        CLS_LBRACE: begin
          ie_emit = 1'b1;
          ie_res  = mk_tok(jst_pkg::KIND_LBRACE);
        end
        CLS_RBRACE: begin
          ie_emit = 1'b1;
          ie_res  = mk_tok(jst_pkg::KIND_RBRACE);
        end
        CLS_LBRACKET: begin
          ie_emit = 1'b1;
          ie_res  = mk_tok(jst_pkg::KIND_LBRACKET);
        end
        CLS_RBRACKET: begin
          ie_emit = 1'b1;
          ie_res  = mk_tok(jst_pkg::KIND_RBRACKET);
        end
        CLS_COLON: begin
          ie_emit = 1'b1;
          ie_res  = mk_tok(jst_pkg::KIND_COLON);
        end
        CLS_COMMA: begin
          ie_emit = 1'b1;
          ie_res  = mk_tok(jst_pkg::KIND_COMMA);
        end
        CLS_QUOTE: begin
          ie_mode   = MODE_STRING;
          ie_cnt_ld = 1'b1;
        end
        CLS_T, CLS_F: begin
          ie_mode   = MODE_LITERAL;
          ie_lit_ld = 1'b1;
        end
        CLS_MINUS, CLS_DIGIT: begin
          ie_emit   = 1'b1;
          ie_res    = mk_text(jst_pkg::KIND_NUMBER, data_byte);
          ie_mode   = MODE_NUMBER;
          ie_cnt_ld = 1'b1;
          ie_cnt    = CW'(1);
        end
        default: begin
          ie_emit = 1'b1;
          ie_res  = mk_err(jst_pkg::ERR_UNEXPECTED);
          ie_mode = MODE_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    count_nxt    = count_r;
    lit_true_nxt = lit_true_r;
    lit_pos_nxt  = lit_pos_r;
    rec          = '0;
    emit         = 1'b0;
    unique case (mode_r)
      MODE_ERROR: ;
      MODE_STRING: begin
        emit = 1'b1;
        if (read_error || end_of_input) begin
          rec.r0   = mk_err(jst_pkg::ERR_UNTERMINATED);
          mode_nxt = MODE_ERROR;
        end else if (cls == CLS_QUOTE) begin
          rec.r0             = mk_tok(jst_pkg::KIND_STRING);
          rec.r0.text_length = jst_pkg::LEN_W'(count_r);
          mode_nxt           = MODE_IDLE;
        end else if (cls == CLS_BSLASH) begin
          rec.r0   = mk_err(jst_pkg::ERR_ESCAPE);
          mode_nxt = MODE_ERROR;
        end else if (full) begin
          rec.r0   = mk_err(jst_pkg::ERR_STRING_LONG);
          mode_nxt = MODE_ERROR;
        end else begin
          rec.r0    = mk_text(jst_pkg::KIND_STRING, data_byte);
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_NUMBER: begin
        emit = 1'b1;
        if (!read_error && !end_of_input && (cls == CLS_DIGIT || cls == CLS_DOT)) begin
          if (full) begin
            rec.r0   = mk_err(jst_pkg::ERR_NUMBER_LONG);
            mode_nxt = MODE_ERROR;
          end else begin
            rec.r0    = mk_text(jst_pkg::KIND_NUMBER, data_byte);
            count_nxt = count_r + CW'(1);
          end
        end else if (!read_error && !end_of_input && cls == CLS_EXP) begin
          rec.r0   = mk_err(jst_pkg::ERR_EXPONENT);
          mode_nxt = MODE_ERROR;
        end else begin
          // The number closes and the same byte starts the next token.
          rec.r0             = mk_tok(jst_pkg::KIND_NUMBER);
          rec.r0.text_length = jst_pkg::LEN_W'(count_r);
          rec.r1             = ie_res;
          rec.two            = ie_emit;
          mode_nxt           = ie_mode;
          if (ie_cnt_ld) count_nxt = ie_cnt;
          if (ie_lit_ld) begin
            lit_true_nxt = (cls == CLS_T);
            lit_pos_nxt  = '0;
          end
        end
      end
      MODE_LITERAL: begin
        if (read_error || end_of_input || !lit[9] || data_byte != lit[7:0]) begin
          emit     = 1'b1;
          rec.r0   = mk_err(jst_pkg::ERR_LITERAL);
          mode_nxt = MODE_ERROR;
        end else if (lit[8]) begin
          emit        = 1'b1;
          rec.r0      = mk_tok(lit_true_r ? jst_pkg::KIND_TRUE : jst_pkg::KIND_FALSE);
          mode_nxt    = MODE_IDLE;
          lit_pos_nxt = '0;
        end else begin
          lit_pos_nxt = lit_pos_r + 3'd1;
        end
      end
      default: begin
        emit     = ie_emit;
        rec.r0   = ie_res;
        mode_nxt = ie_mode;
        if (ie_cnt_ld) count_nxt = ie_cnt;
        if (ie_lit_ld) begin
          lit_true_nxt = (cls == CLS_T);
          lit_pos_nxt  = '0;
        end
      end
    endcase
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      count_r    <= '0;
      lit_true_r <= 1'b0;
      lit_pos_r  <= '0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      count_r    <= count_nxt;
      lit_true_r <= lit_true_nxt;
      lit_pos_r  <= lit_pos_nxt;
    end
  end

endmodule

// File: hdl/jst_queue.sv
// ----------------------------------------------------------------------------
// jst_queue
// Short first-in first-out queue of result records between the lexer front
// end and the output serialiser.
// ----------------------------------------------------------------------------
module jst_queue #(
  parameter int DEPTH = jst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jst_pkg::rec_t push_rec,
  output logic          ready,
  input  logic          pop,
  output logic          head_valid,
  output jst_pkg::rec_t head_rec
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  jst_pkg::rec_t entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] fill_r;

  function automatic logic [AW-1:0] step(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign ready      = (fill_r != NW'(DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_rec   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && ready) entry_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push && ready) wr_ptr_r <= step(wr_ptr_r);
      if (pop && head_valid) rd_ptr_r <= step(rd_ptr_r);
      case ({push && ready, pop && head_valid})
        2'b10:   fill_r <= fill_r + NW'(1);
        2'b01:   fill_r <= fill_r - NW'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// File: hdl/jst_back.sv
// ----------------------------------------------------------------------------
// jst_back
// Output serialiser: presents the results of queued records in an output
// register, one per cycle when not stalled, marking the last of each record.
// ----------------------------------------------------------------------------
module jst_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  jst_pkg::rec_t head_rec,
  output logic          pop,
  input  logic          out_stall,
  output logic          out_valid,
  output jst_pkg::res_t out_res,
  output logic          out_last
);

  logic          valid_r, valid_nxt;
  logic          half_r, half_nxt;
  jst_pkg::res_t res_r, res_nxt;
  logic          last_r, last_nxt;
  logic          load;

  assign load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        if (head_rec.two && !half_r) begin
          res_nxt  = head_rec.r0;
          last_nxt = 1'b0;
          half_nxt = 1'b1;
        end else begin
          res_nxt  = half_r ? head_rec.r1 : head_rec.r0;
          last_nxt = 1'b1;
          half_nxt = 1'b0;
          pop      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

// File: hdl/json_subset_tokenizer.sv
// ----------------------------------------------------------------------------
// json_subset_tokenizer
// Streaming tokenizer for a subset of JSON, one source byte per transfer.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake         | Payload
//   --------+-----------+-------------------+-----------------------------------
//   in_     | input     | in_valid/in_stall | data_byte, end_of_input, read_error
//   out_    | output    | out_valid/out_stall | is_token, token_kind, text_byte,
//           |           |                   | text_length, error_code, last
//
// A source byte is taken in every cycle in which the queue has room; it is
// classified and its results are worked out in that same cycle and written
// into the queue, from which they are loaded into the output register.
// A byte that closes a number and starts another token gives two results and
// occupies the output register once for each; the queue absorbs the slip.
// Reset is synchronous and active low; it clears the lexer state, the queue
// and the output register. There is no clearing pass.
// in_stall is high only while the queue is full; out_stall holds the output
// register and, once the queue fills behind it, the input.
//
module json_subset_tokenizer #(
  parameter int TEXT_MAX    = jst_pkg::TEXT_MAX_DEF,
  parameter int QUEUE_DEPTH = jst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_input,
  input  logic       in_read_error,

  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_token,
  output logic [3:0] out_token_kind,
  output logic [7:0] out_text_byte,
  output logic [4:0] out_text_length,
  output logic [3:0] out_error_code,
  output logic       out_last
);

  // Front end to queue.
  logic          in_accept;
  logic          push;
  logic          q_ready;
  jst_pkg::rec_t push_rec;

  // Queue to back end.
  logic          head_valid;
  logic          pop;
  jst_pkg::rec_t head_rec;

  jst_pkg::res_t out_res;

  // Every byte, even one that yields nothing, waits for room in the queue,
  // which keeps the front end free of any look at the output side.
  assign in_stall  = !q_ready;
  assign in_accept = in_valid && !in_stall;

  jst_front #(
    .TEXT_MAX (TEXT_MAX)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .data_byte    (in_data_byte),
    .end_of_input (in_end_of_input),
    .read_error   (in_read_error),
    .push         (push),
    .rec          (push_rec)
  );

  jst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // The back end pops a record only when its final result is loaded into
  // the output register, so a two-result record stays at the queue head
  // until its second result is loaded.
  jst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .out_last   (out_last)
  );

  assign out_is_token    = out_res.is_token;
  assign out_token_kind  = out_res.token_kind;
  assign out_text_byte   = out_res.text_byte;
  assign out_text_length = out_res.text_length;
  assign out_error_code  = out_res.error_code;

endmodule

// File: hdl/jst_checker.sv
// ----------------------------------------------------------------------------
// jst_checker
// Port-level checks on the tokenizer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_subset_tokenizer_assert.svh"

module jst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_is_token,
  input logic [3:0] out_token_kind,
  input logic [4:0] out_text_length,
  input logic [3:0] out_error_code,
  input logic       out_last
);

  logic err_xfer;

  assign err_xfer = out_valid && !out_stall && out_token_kind == jst_pkg::KIND_ERROR;

  // A stalled result keeps its kind and its last mark.
  `JST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_token_kind) && $stable(out_last), "result changed while stalled")

  // A text byte belongs to a string or a number and carries no length or code.
  `JST_ASSERT_NOW(a_text_shape, out_valid && !out_is_token, (out_token_kind == jst_pkg::KIND_STRING || out_token_kind == jst_pkg::KIND_NUMBER) && out_text_length == 5'd0 && out_error_code == jst_pkg::ERR_NONE, "malformed text byte result")

  // An error is a token with a code and always closes its input item.
  `JST_ASSERT_NOW(a_err_shape, out_valid && out_token_kind == jst_pkg::KIND_ERROR, out_is_token && out_last && out_error_code != jst_pkg::ERR_NONE, "malformed error result")

  // Errors are sticky: nothing follows a transferred error until reset.
  `JST_ASSERT_NEXT(a_err_sticky, err_xfer, !out_valid, "result after an error")

endmodule

bind json_subset_tokenizer jst_checker u_jst_checker (.*);
